// ===== rtl/vdce_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector display command engine package
// Shared types, command codes and a helper function for the engine.
// ----------------------------------------------------------------------------
package vdce_pkg;

  typedef enum logic [1:0] {
    ACT_CMD   = 2'd0,
    ACT_START = 2'd1,
    ACT_RESET = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MOVE = 2'd1,
    OP_LINE = 2'd2
  } beam_op_e;

  localparam logic [7:0]  CTRL_CODE    = 8'h80;
  localparam logic [6:0]  MAG_MASK     = 7'h7F;
  localparam logic [7:0]  WORD_COST    = 8'd6;
  localparam logic [15:0] MASK_RESET   = 16'd8191;

  // Bit positions of the control byte.
  localparam int unsigned CTRL_BIT_EN  = 0;
  localparam int unsigned CTRL_BIT_BEAM = 1;
  localparam int unsigned CTRL_BIT_IRQ = 2;
  localparam int unsigned CTRL_BIT_REL = 3;

  typedef struct packed {
    action_e     action;
    logic [15:0] start_addr;
    logic [7:0]  byte_x;
    logic [7:0]  byte_y;
  } item_t;

  typedef struct packed {
    logic       rel_mode;
    logic       beam_on;
    logic       enabled;
    logic       irq_flag;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } state_t;

  typedef struct packed {
    logic signed [7:0] beam_x;
    logic signed [7:0] beam_y;
    beam_op_e          beam_op;
    logic [7:0]        cost;
    logic [15:0]       fetch_addr;
    logic              drawing;
    logic              interrupt;
  } result_t;

  // Sign-magnitude byte to two's complement delta.
  function automatic logic [7:0] sm_delta(logic [7:0] b);
    logic [7:0] mag;
    mag = {1'b0, b[6:0] & MAG_MASK};
    return b[7] ? 8'(8'd0 - mag) : mag;
  endfunction

endpackage

// ===== rtl/vdce_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Vector display command channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface vdce_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] start_addr;
  logic [7:0]  byte_x;
  logic [7:0]  byte_y;

  modport source (output valid, output action, output start_addr, output byte_x,
                  output byte_y, input ready);
  modport sink   (input valid, input action, input start_addr, input byte_x,
                  input byte_y, output ready);
endinterface

// ===== rtl/vdce_res_if.sv =====
// ----------------------------------------------------------------------------
// Vector display result channel
// Valid/ready channel that carries one beam result per transfer.
// ----------------------------------------------------------------------------
interface vdce_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] beam_x;
  logic signed [7:0] beam_y;
  logic [1:0]        beam_op;
  logic [7:0]        cost;
  logic [15:0]       fetch_addr;
  logic              drawing;
  logic              interrupt;

  modport source (output valid, output beam_x, output beam_y, output beam_op,
                  output cost, output fetch_addr, output drawing, output interrupt,
                  input ready);
  modport sink   (input valid, input beam_x, input beam_y, input beam_op,
                  input cost, input fetch_addr, input drawing, input interrupt,
                  output ready);
endinterface

// ===== rtl/vdce_in_reg.sv =====
// ----------------------------------------------------------------------------
// Vector display input register
// Captures one command transfer and holds it until the execute stage moves.
// ----------------------------------------------------------------------------
module vdce_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  vdce_cmd_if.sink       cmd_i,
  input  logic           advance_i,
  output logic           valid_o,
  output vdce_pkg::item_t item_o
);
  import vdce_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The register frees up whenever its item moves on in the same cycle.
  assign cmd_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      item_q.action     <= action_e'(cmd_i.action);
      item_q.start_addr <= cmd_i.start_addr;
      item_q.byte_x     <= cmd_i.byte_x;
      item_q.byte_y     <= cmd_i.byte_y;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== rtl/vdce_exec.sv =====
// ----------------------------------------------------------------------------
// Vector display command execute logic
// Decodes one item against the engine state and forms next state and result.
// ----------------------------------------------------------------------------
module vdce_exec #(
  parameter int unsigned ADDR_WIDTH = 16
) (
  input  vdce_pkg::item_t   item_i,
  input  vdce_pkg::state_t  state_i,
  input  logic [ADDR_WIDTH-1:0] cmd_addr_i,
  input  logic [15:0]       mask_i,
  output vdce_pkg::state_t  state_o,
  output logic [ADDR_WIDTH-1:0] cmd_addr_o,
  output vdce_pkg::result_t res_o
);
  import vdce_pkg::*;

  // Only the low bits of the mask and of the start address that the address
  // register can hold take part.
  localparam int unsigned MW = (ADDR_WIDTH < 16) ? ADDR_WIDTH : 16;

  logic [ADDR_WIDTH-1:0] eff_mask;
  logic [ADDR_WIDTH-1:0] cur_addr;
  logic [ADDR_WIDTH-1:0] next_addr;
  logic [ADDR_WIDTH-1:0] out_addr;
  logic [6:0]            mag_x;
  logic [6:0]            mag_y;
  logic [6:0]            max_mag;
  beam_op_e              op;
  logic [7:0]            cost;

  assign eff_mask  = ADDR_WIDTH'(mask_i[MW-1:0]);
  assign cur_addr  = cmd_addr_i & eff_mask;
  assign next_addr = (cur_addr + ADDR_WIDTH'(2)) & eff_mask;
  assign mag_x     = item_i.byte_x[6:0];
  assign mag_y     = item_i.byte_y[6:0];
  assign max_mag   = (mag_x > mag_y) ? mag_x : mag_y;

  always_comb begin
    state_o    = state_i;
    cmd_addr_o = cmd_addr_i;
    op         = OP_NONE;
    cost       = '0;
    unique case (item_i.action)
      ACT_START: begin
        cmd_addr_o       = ADDR_WIDTH'(item_i.start_addr[MW-1:0]);
        state_o.rel_mode = 1'b1;
        state_o.irq_flag = 1'b0;
        state_o.beam_on  = 1'b1;
        state_o.enabled  = 1'b1;
      end
      ACT_RESET: begin
        state_o.enabled  = 1'b0;
        state_o.beam_on  = 1'b0;
        state_o.irq_flag = 1'b0;
      end
      ACT_CMD: begin
        if (state_i.enabled) begin
          cmd_addr_o = next_addr;
          cost       = WORD_COST;
          if (state_i.rel_mode) begin
            if (item_i.byte_x == CTRL_CODE) begin
              state_o.rel_mode = item_i.byte_y[CTRL_BIT_REL];
              state_o.beam_on  = item_i.byte_y[CTRL_BIT_BEAM];
              state_o.enabled  = item_i.byte_y[CTRL_BIT_EN];
              if (!item_i.byte_y[CTRL_BIT_EN]) begin
                state_o.irq_flag = item_i.byte_y[CTRL_BIT_IRQ];
              end
            end else begin
              cost          = WORD_COST + {1'b0, max_mag};
              state_o.pos_x = state_i.pos_x + sm_delta(item_i.byte_x);
              state_o.pos_y = state_i.pos_y + sm_delta(item_i.byte_y);
              if (state_i.beam_on) begin
                op = OP_LINE;
              end else begin
                op               = OP_MOVE;
                state_o.rel_mode = 1'b1;
                state_o.beam_on  = 1'b1;
              end
            end
          end else begin
            state_o.pos_x    = item_i.byte_x;
            state_o.pos_y    = item_i.byte_y;
            op               = OP_MOVE;
            state_o.rel_mode = 1'b1;
            state_o.beam_on  = 1'b1;
          end
        end
      end
      default: begin
        // Unused action code: nothing changes.
      end
    endcase
  end

  assign out_addr = cmd_addr_o & eff_mask;

  assign res_o.beam_x     = $signed(state_o.pos_x);
  assign res_o.beam_y     = $signed(state_o.pos_y);
  assign res_o.beam_op    = op;
  assign res_o.cost       = cost;
  assign res_o.fetch_addr = 16'(out_addr[MW-1:0]);
  assign res_o.drawing    = state_o.enabled;
  assign res_o.interrupt  = state_o.irq_flag;
endmodule

// ===== rtl/vector_display_command_engine_core.sv =====
// ----------------------------------------------------------------------------
// Vector display command engine core
// Steps a two-byte drawing command list and drives the beam position counters.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the cmd_i channel: a start action loads the fetch address
//   and opens a frame, a reset action stops drawing, and a command action
//   carries the two command bytes fetched at the current fetch address.
//   Every item yields exactly one result transfer on res_o with the beam
//   position, the beam operation (none, move or line), the cost of the
//   command, the next fetch address and the drawing and interrupt flags.
//   The user writes the address wrap mask through cfg_we_i / cfg_wdata_i only
//   while the engine is idle (not enforced by the block); it resets to 8191.
// Timing:
//   An item is decoded and applied to the state while it sits in the input
//   register, and its result is captured in the result register when the
//   execute stage moves. One item is taken per clock while the receiver
//   takes results; the rate is set by the single decode-and-add path
//   between the input register and the result register.
// Reset and stalls:
//   Reset clears the mode flags, position counters, fetch address and both
//   valid flags. While the receiver holds off, the result register keeps its
//   value, the input register fills and then ready drops on cmd_i.
// ----------------------------------------------------------------------------
module vector_display_command_engine_core #(
  parameter int unsigned ADDR_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  vdce_cmd_if.sink    cmd_i,
  vdce_res_if.source  res_o
);
  import vdce_pkg::*;

  // Configuration: address wrap mask.
  logic [15:0] addr_mask_q;

  // Engine state.
  state_t                state_q;
  state_t                state_d;
  logic [ADDR_WIDTH-1:0] cmd_addr_q;
  logic [ADDR_WIDTH-1:0] cmd_addr_d;

  // Pipeline between the input register and the result register.
  logic    item_valid;
  item_t   item;
  logic    advance;
  logic    fire;
  result_t res_d;
  result_t res_q;
  logic    res_valid_q;

  // The execute stage moves when the result register is empty or being read.
  assign advance = !res_valid_q || res_o.ready;
  assign fire    = item_valid && advance;

  vdce_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  vdce_exec #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_exec (
    .item_i     (item),
    .state_i    (state_q),
    .cmd_addr_i (cmd_addr_q),
    .mask_i     (addr_mask_q),
    .state_o    (state_d),
    .cmd_addr_o (cmd_addr_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      addr_mask_q <= cfg_wdata_i;
    end
  end

  // State and result are committed together when an item leaves the input
  // register, so the next item always sees the state this one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      cmd_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q    <= state_d;
        cmd_addr_q <= cmd_addr_d;
      end
      if (advance) begin
        res_valid_q <= item_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.beam_x     = res_q.beam_x;
  assign res_o.beam_y     = res_q.beam_y;
  assign res_o.beam_op    = res_q.beam_op;
  assign res_o.cost       = res_q.cost;
  assign res_o.fetch_addr = res_q.fetch_addr;
  assign res_o.drawing    = res_q.drawing;
  assign res_o.interrupt  = res_q.interrupt;

  // A reset action must leave the engine stopped with no pending interrupt.
  a_reset_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item.action == ACT_RESET) |=>
      (res_valid_q && !res_q.drawing && !res_q.interrupt))
    else $error("reset action did not stop the engine");

  // Any beam movement comes from a fetched word and so costs at least a word.
  a_op_cost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.beam_op != OP_NONE) |-> (res_q.cost >= WORD_COST))
    else $error("beam operation reported without word cost");

  // While the receiver stalls a full result register, the engine state holds.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |=> ($stable(cmd_addr_q) && $stable(state_q)))
    else $error("engine state changed during a result stall");

  // A command word that is not fetched costs nothing and moves nothing.
  a_idle_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item.action == ACT_CMD && !state_q.enabled) |=>
      (res_q.cost == 8'd0 && res_q.beam_op == OP_NONE))
    else $error("command word processed while not drawing");
endmodule
